// ===== rtl/mft_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mft_pkg;

	localparam int SCREEN_WIDTH = 320;
	localparam int HALF_WIDTH = SCREEN_WIDTH / 2;
	localparam int TILE_SIDE = 64;
	localparam int TILE_BITS = $clog2(TILE_SIDE);
	localparam int ADDR_BITS = 2 * TILE_BITS;

	localparam int DIST_NW = 32;
	localparam int DIST_DW = 10;
	localparam int HS_NW = 48;
	localparam int HS_DW = 32;

	localparam logic signed [31:0] FX_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] FX_NMAX = 32'sh8000_0001;
	localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
	localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_RENDER = 1'b1;

	typedef enum logic [3:0] {
		REG_CAMERA_HEIGHT = 4'd0,
		REG_HORIZON_OFFSET = 4'd1,
		REG_SCALE_ACROSS = 4'd2,
		REG_SCALE_DEPTH = 4'd3,
		REG_CAMERA_POS_X = 4'd4,
		REG_CAMERA_POS_Y = 4'd5,
		REG_VIEW_COSINE = 4'd6,
		REG_VIEW_SINE = 4'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] camera_height;
		logic signed [9:0] horizon_offset;
		logic signed [31:0] scale_across;
		logic signed [31:0] scale_depth;
		logic signed [31:0] camera_pos_x;
		logic signed [31:0] camera_pos_y;
		logic signed [17:0] view_cosine;
		logic signed [17:0] view_sine;
	} cfg_t;

	typedef struct packed {
		logic op;
		logic [ADDR_BITS-1:0] addr;
		logic [7:0] texel;
		logic [8:0] px;
		logic [7:0] py;
	} item_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > SAT_HI) begin
			r = FX_MAX;
		end else if (v < SAT_LO) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/mft_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mft_front
	import mft_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic full,
	input  wire logic operation,
	input  wire logic [5:0] tile_col,
	input  wire logic [5:0] tile_row,
	input  wire logic [7:0] texel_value,
	input  wire logic [8:0] pixel_col,
	input  wire logic [7:0] pixel_row,
	input  wire logic take,
	output logic avail,
	output item_t head
);

	item_t fifo_q [4];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] cnt_q;
	item_t in_item;
	logic wr, rd;

	always_comb begin
		in_item.op = operation;
		in_item.addr = (operation == OP_LOAD) ? {tile_row, tile_col} : '0;
		in_item.texel = texel_value;
		in_item.px = pixel_col;
		in_item.py = pixel_row;
	end

	assign full = (cnt_q == 3'd4);
	assign avail = (cnt_q != 3'd0);
	assign head = fifo_q[rd_ptr_q];
	assign wr = push && !full;
	assign rd = take && avail;

	always_ff @(posedge clk) begin
		if (wr) begin
			fifo_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wr_ptr_q <= wr_ptr_q + 2'd1;
			if (rd) rd_ptr_q <= rd_ptr_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, wr} - {2'b0, rd};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/mft_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mft_div #(
	parameter int NW = 32,
	parameter int DW = 10
) (
	input  wire logic clk,
	input  wire logic en,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem
);

	logic [NW-1:0] qn_q [NW];
	logic [DW-1:0] r_q [NW];
	logic [DW-1:0] d_q [NW];

	for (genvar i = 0; i < NW; i++) begin : g_st
		logic [NW-1:0] qn_in;
		logic [DW-1:0] r_in, d_in;
		logic [DW:0] t;
		logic [DW:0] diff;
		logic ge;
		if (i == 0) begin : g_first
			assign qn_in = num;
			assign r_in = '0;
			assign d_in = den;
		end else begin : g_next
			assign qn_in = qn_q[i-1];
			assign r_in = r_q[i-1];
			assign d_in = d_q[i-1];
		end
		assign t = {r_in, qn_in[NW-1]};
		assign diff = t - {1'b0, d_in};
		assign ge = (t >= {1'b0, d_in});
		always_ff @(posedge clk) begin
			if (en) begin
				qn_q[i] <= {qn_in[NW-2:0], ge};
				r_q[i] <= ge ? diff[DW-1:0] : t[DW-1:0];
				d_q[i] <= d_in;
			end
		end
	end

	assign quo = qn_q[NW-1];
	assign rem = r_q[NW-1];

endmodule
`default_nettype wire

// ===== rtl/mft_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mft_back
	import mft_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic avail,
	input  wire item_t head,
	output logic take,
	output logic empty,
	input  wire logic pop,
	output logic [8:0] out_col,
	output logic [7:0] out_row,
	output logic [7:0] colour
);

	typedef struct packed {
		item_t item;
		logic num_neg;
		logic den_neg;
		logic den_zero;
	} side1_t;

	typedef struct packed {
		item_t item;
		logic signed [31:0] bx0;
		logic signed [31:0] by0;
		logic dist_neg;
	} side2_t;

	typedef struct packed {
		item_t item;
		logic signed [31:0] bx0;
		logic signed [31:0] by0;
	} trk_t;

	logic en;
	logic out_valid_q;
	logic [8:0] out_col_q;
	logic [7:0] out_row_q;
	logic [7:0] colour_q;
	logic [7:0] mem [TILE_SIDE*TILE_SIDE];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic v1_q [DIST_NW];
	logic v2_q [HS_NW];
	side1_t side1_q [DIST_NW];
	side2_t side2_q [HS_NW];

	item_t item_s1, item_s2, item_s4, item_s10;
	logic signed [63:0] prod_s1;
	logic signed [10:0] den_s1;

	logic [31:0] num_abs_s2;
	logic [DIST_DW-1:0] den_abs_s2;
	logic num_neg_s2, den_neg_s2, den_zero_s2;

	side1_t sd1_s3;
	logic signed [31:0] dist_s3;

	logic signed [49:0] pc_s4, ps_s4;
	logic [HS_NW-1:0] n2_s4, n2_s5;
	logic [HS_DW-1:0] d2_s4, d2_s5;
	logic dist_neg_s4, dist_neg_s5;
	item_t item_s5;
	logic signed [31:0] bx0_s5, by0_s5;

	trk_t trk_s6, trk_s7, trk_s8;
	logic signed [31:0] hs_s6;
	logic signed [50:0] psx_s7, psy_s7;
	logic signed [31:0] sx_s8, sy_s8;
	item_t item_s9;
	logic signed [31:0] bx_s9, by_s9;
	logic [31:0] mx_s9, my_s9;
	logic [ADDR_BITS-1:0] addr_s10;

	logic [DIST_NW-1:0] q1;
	logic [DIST_DW-1:0] r1;
	logic [HS_NW-1:0] q2;
	logic [HS_DW-1:0] r2;

	assign en = !out_valid_q || pop;
	assign take = en && avail;
	assign empty = !out_valid_q;
	assign out_col = out_col_q;
	assign out_row = out_row_q;
	assign colour = colour_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < DIST_NW; k++) v1_q[k] <= 1'b0;
			for (int k = 0; k < HS_NW; k++) v2_q[k] <= 1'b0;
		end else if (en) begin
			v_s1 <= avail;
			v_s2 <= v_s1;
			v1_q[0] <= v_s2;
			for (int k = 1; k < DIST_NW; k++) v1_q[k] <= v1_q[k-1];
			v_s3 <= v1_q[DIST_NW-1];
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v2_q[0] <= v_s5;
			for (int k = 1; k < HS_NW; k++) v2_q[k] <= v2_q[k-1];
			v_s6 <= v2_q[HS_NW-1];
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			out_valid_q <= v_s10 && (item_s10.op == OP_RENDER);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= head;
			prod_s1 <= 64'(cfg.camera_height) * 64'(cfg.scale_depth);
			den_s1 <= $signed({3'b000, head.py}) + 11'(cfg.horizon_offset);
		end
	end

	logic signed [63:0] pr1;
	logic signed [31:0] num2;
	logic signed [10:0] nden;
	assign pr1 = prod_s1 + 64'sd32768;
	assign num2 = sat32(66'($signed(pr1[63:16])));
	assign nden = -den_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2 <= item_s1;
			num_neg_s2 <= num2[31];
			num_abs_s2 <= num2[31] ? 32'(-num2) : num2;
			den_neg_s2 <= den_s1[10];
			den_zero_s2 <= (den_s1 == 11'sd0);
			den_abs_s2 <= den_s1[10] ? nden[DIST_DW-1:0] : den_s1[DIST_DW-1:0];
		end
	end

	mft_div #(.NW(DIST_NW), .DW(DIST_DW)) u_div_dist (
		.clk(clk),
		.en(en),
		.num(num_abs_s2),
		.den(den_abs_s2),
		.quo(q1),
		.rem(r1)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side1_q[0] <= '{item: item_s2, num_neg: num_neg_s2, den_neg: den_neg_s2,
				den_zero: den_zero_s2};
			for (int k = 1; k < DIST_NW; k++) side1_q[k] <= side1_q[k-1];
		end
	end

	side1_t sd1;
	logic signed [32:0] qs1;
	logic signed [31:0] dist3;
	assign sd1 = side1_q[DIST_NW-1];
	assign qs1 = (sd1.num_neg ^ sd1.den_neg) ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
	always_comb begin
		if (sd1.den_zero) begin
			dist3 = sd1.num_neg ? FX_NMAX : FX_MAX;
		end else begin
			dist3 = sat32(66'(qs1));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd1_s3 <= sd1;
			dist_s3 <= dist3;
		end
	end

	logic [31:0] dist_abs;
	logic [31:0] scale_abs;
	assign dist_abs = dist_s3[31] ? 32'(-dist_s3) : dist_s3;
	assign scale_abs = cfg.scale_across[31] ? 32'(-cfg.scale_across) : cfg.scale_across;

	always_ff @(posedge clk) begin
		if (en) begin
			item_s4 <= sd1_s3.item;
			pc_s4 <= 50'(dist_s3) * 50'(cfg.view_cosine);
			ps_s4 <= 50'(dist_s3) * 50'(cfg.view_sine);
			n2_s4 <= {dist_abs, 16'h0000};
			d2_s4 <= scale_abs;
			dist_neg_s4 <= dist_s3[31];
		end
	end

	logic signed [49:0] pcr, psr;
	logic signed [31:0] fcx, fcy;
	assign pcr = pc_s4 + 50'sd32768;
	assign psr = ps_s4 + 50'sd32768;
	assign fcx = sat32(66'($signed(pcr[49:16])));
	assign fcy = sat32(66'($signed(psr[49:16])));

	always_ff @(posedge clk) begin
		if (en) begin
			item_s5 <= item_s4;
			n2_s5 <= n2_s4;
			d2_s5 <= d2_s4;
			dist_neg_s5 <= dist_neg_s4;
			bx0_s5 <= sat32(66'(cfg.camera_pos_x) + 66'(fcx));
			by0_s5 <= sat32(66'(cfg.camera_pos_y) + 66'(fcy));
		end
	end

	mft_div #(.NW(HS_NW), .DW(HS_DW)) u_div_hs (
		.clk(clk),
		.en(en),
		.num(n2_s5),
		.den(d2_s5),
		.quo(q2),
		.rem(r2)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side2_q[0] <= '{item: item_s5, bx0: bx0_s5, by0: by0_s5, dist_neg: dist_neg_s5};
			for (int k = 1; k < HS_NW; k++) side2_q[k] <= side2_q[k-1];
		end
	end

	side2_t sd2;
	logic rnd;
	logic [HS_NW:0] qq;
	logic signed [HS_NW+1:0] qs2;
	logic signed [31:0] hs6;
	assign sd2 = side2_q[HS_NW-1];
	assign rnd = ({r2, 1'b0} >= {1'b0, scale_abs});
	assign qq = {1'b0, q2} + {{HS_NW{1'b0}}, rnd};
	assign qs2 = (sd2.dist_neg ^ cfg.scale_across[31]) ? -$signed({1'b0, qq})
		: $signed({1'b0, qq});
	always_comb begin
		if (cfg.scale_across == 32'sd0) begin
			hs6 = sd2.dist_neg ? FX_NMAX : FX_MAX;
		end else begin
			hs6 = sat32(66'(qs2));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			trk_s6 <= '{item: sd2.item, bx0: sd2.bx0, by0: sd2.by0};
			hs_s6 <= hs6;
		end
	end

	logic signed [18:0] msin;
	assign msin = -19'(cfg.view_sine);

	always_ff @(posedge clk) begin
		if (en) begin
			trk_s7 <= trk_s6;
			psx_s7 <= 51'(msin) * 51'(hs_s6);
			psy_s7 <= 51'(cfg.view_cosine) * 51'(hs_s6);
		end
	end

	logic signed [50:0] sxr, syr;
	assign sxr = psx_s7 + 51'sd32768;
	assign syr = psy_s7 + 51'sd32768;

	always_ff @(posedge clk) begin
		if (en) begin
			trk_s8 <= trk_s7;
			sx_s8 <= sat32(66'($signed(sxr[50:16])));
			sy_s8 <= sat32(66'($signed(syr[50:16])));
		end
	end

	logic signed [41:0] hx, hy;
	assign hx = 42'(trk_s8.bx0) - 42'(sx_s8) * 42'(HALF_WIDTH);
	assign hy = 42'(trk_s8.by0) - 42'(sy_s8) * 42'(HALF_WIDTH);

	always_ff @(posedge clk) begin
		if (en) begin
			item_s9 <= trk_s8.item;
			bx_s9 <= sat32(66'(hx));
			by_s9 <= sat32(66'(hy));
			mx_s9 <= $unsigned(sx_s8) * {23'b0, trk_s8.item.px};
			my_s9 <= $unsigned(sy_s8) * {23'b0, trk_s8.item.px};
		end
	end

	logic [31:0] ux, uy;
	assign ux = $unsigned(bx_s9) + mx_s9 + 32'h0000_8000;
	assign uy = $unsigned(by_s9) + my_s9 + 32'h0000_8000;

	always_ff @(posedge clk) begin
		if (en) begin
			item_s10 <= item_s9;
			addr_s10 <= (item_s9.op == OP_LOAD) ? item_s9.addr
				: {uy[16 +: TILE_BITS], ux[16 +: TILE_BITS]};
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s10) begin
			if (item_s10.op == OP_LOAD) begin
				mem[addr_s10] <= item_s10.texel;
			end else begin
				colour_q <= mem[addr_s10];
				out_col_q <= item_s10.px;
				out_row_q <= item_s10.py;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/mode7_floor_texture_mapper_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Perspective floor mapper: load transactions fill a 64x64 tile of 8-bit texels, render
// transactions return the texel seen at a screen pixel. One transaction is taken per clock
// while the result register is empty or being popped; the pipeline holds two dividers,
// 32 stages for the line distance and 48 for the step size. Loads travel the same
// pipeline, so a render always sees every earlier load. The tile store is not cleared
// by reset and must be written before it is read. Configuration is taken every cycle
// and must only change while no transaction is in flight.
module mode7_floor_texture_mapper_unit
	import mft_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic full,
	input  wire logic operation,
	input  wire logic [5:0] tile_col,
	input  wire logic [5:0] tile_row,
	input  wire logic [7:0] texel_value,
	input  wire logic [8:0] pixel_col,
	input  wire logic [7:0] pixel_row,
	output logic empty,
	input  wire logic pop,
	output logic [8:0] out_col,
	output logic [7:0] out_row,
	output logic [7:0] colour,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [3:0] cfg_index,
	input  wire logic [31:0] cfg_data
);

	cfg_t cfg_q;
	logic take, avail;
	item_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.camera_height <= 32'sd3276800;
			cfg_q.horizon_offset <= 10'sd20;
			cfg_q.scale_across <= 32'sd13107200;
			cfg_q.scale_depth <= 32'sd13107200;
			cfg_q.camera_pos_x <= 32'sd0;
			cfg_q.camera_pos_y <= 32'sd0;
			cfg_q.view_cosine <= 18'sd65536;
			cfg_q.view_sine <= 18'sd0;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_CAMERA_HEIGHT: cfg_q.camera_height <= cfg_data;
				REG_HORIZON_OFFSET: cfg_q.horizon_offset <= cfg_data[9:0];
				REG_SCALE_ACROSS: cfg_q.scale_across <= cfg_data;
				REG_SCALE_DEPTH: cfg_q.scale_depth <= cfg_data;
				REG_CAMERA_POS_X: cfg_q.camera_pos_x <= cfg_data;
				REG_CAMERA_POS_Y: cfg_q.camera_pos_y <= cfg_data;
				REG_VIEW_COSINE: cfg_q.view_cosine <= cfg_data[17:0];
				REG_VIEW_SINE: cfg_q.view_sine <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	mft_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.operation(operation),
		.tile_col(tile_col),
		.tile_row(tile_row),
		.texel_value(texel_value),
		.pixel_col(pixel_col),
		.pixel_row(pixel_row),
		.take(take),
		.avail(avail),
		.head(head)
	);

	mft_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.avail(avail),
		.head(head),
		.take(take),
		.empty(empty),
		.pop(pop),
		.out_col(out_col),
		.out_row(out_row),
		.colour(colour)
	);

endmodule
`default_nettype wire

// ===== rtl/mft_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mft_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic full,
	input wire logic empty,
	input wire logic pop,
	input wire logic [8:0] out_col,
	input wire logic [7:0] out_row,
	input wire logic [7:0] colour,
	input wire logic cfg_ready
);

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(colour) && $stable(out_col)
			&& $stable(out_row)))
		else $error("waiting result changed");

	a_full_needs_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("queue filled without a transaction");

	a_empty_needs_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(empty) |-> $past(pop))
		else $error("result dropped without a pop");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port stalled");

endmodule

bind mode7_floor_texture_mapper_unit mft_checker u_mft_checker (
	.clk(clk),
	.arst_n(arst_n),
	.push(push),
	.full(full),
	.empty(empty),
	.pop(pop),
	.out_col(out_col),
	.out_row(out_row),
	.colour(colour),
	.cfg_ready(cfg_ready)
);
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import mft_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 120;
	localparam int LONG_HOLD = 400;
	localparam logic [3:0] REG_UNUSED = 4'd15;
	localparam longint SAT_MAX = 64'sd2147483647;
	localparam longint SAT_MIN = -64'sd2147483648;

	typedef struct {
		bit op;
		bit [5:0] tcol;
		bit [5:0] trow;
		bit [7:0] texel;
		bit [8:0] x;
		bit [7:0] y;
	} pix_job_t;

	typedef struct {
		bit [8:0] x;
		bit [7:0] y;
		bit [7:0] colour;
	} texel_hit_t;

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic full;
	logic operation = 0;
	logic [5:0] tile_col = 0;
	logic [5:0] tile_row = 0;
	logic [7:0] texel_value = 0;
	logic [8:0] pixel_col = 0;
	logic [7:0] pixel_row = 0;
	logic empty;
	logic pop = 0;
	logic [8:0] out_col;
	logic [7:0] out_row;
	logic [7:0] colour;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [3:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;

	pix_job_t jobs[$];
	texel_hit_t hits_due[$];
	bit [7:0] tile[TILE_SIDE*TILE_SIDE];
	longint m_height, m_horizon, m_sacross, m_sdepth, m_posx, m_posy, m_cos, m_sin;
	int errors = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int stall_mode = 0;
	int stall_count = 0;
	int idle_cycles = 0;

	mode7_floor_texture_mapper_unit uut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint clamp32(input longint v);
		if (v > SAT_MAX) return SAT_MAX;
		if (v < SAT_MIN) return SAT_MIN;
		return v;
	endfunction

	function automatic longint fx_mul(input longint a, input longint b);
		longint p;
		p = a * b + 32768;
		return clamp32(p >>> 16);
	endfunction

	function automatic longint fx_div(input longint a, input longint b);
		longint n, an, ab, q, r;
		if (b == 0) return (a < 0) ? -SAT_MAX : SAT_MAX;
		n = a * 65536;
		an = (n < 0) ? -n : n;
		ab = (b < 0) ? -b : b;
		q = an / ab;
		r = an % ab;
		if (2 * r >= ab) q++;
		if ((n < 0) != (b < 0)) q = -q;
		return clamp32(q);
	endfunction

	function automatic bit [7:0] floor_texel(input bit [8:0] x, input bit [7:0] y);
		longint num, den, line_dist, hs, sx, sy, bx, by;
		bit [31:0] ux, uy, ix, iy;
		num = fx_mul(m_height, m_sdepth);
		den = longint'(y) + m_horizon;
		if (den == 0) line_dist = (num < 0) ? -SAT_MAX : SAT_MAX;
		else line_dist = clamp32(num / den);
		hs = fx_div(line_dist, m_sacross);
		sx = fx_mul(-m_sin, hs);
		sy = fx_mul(m_cos, hs);
		bx = clamp32(m_posx + fx_mul(line_dist, m_cos));
		bx = clamp32(bx - HALF_WIDTH * sx);
		by = clamp32(m_posy + fx_mul(line_dist, m_sin));
		by = clamp32(by - HALF_WIDTH * sy);
		ux = bx[31:0] + 32'(x) * sx[31:0];
		uy = by[31:0] + 32'(x) * sy[31:0];
		ix = ((ux + 32'h8000) >> 16) & (TILE_SIDE - 1);
		iy = ((uy + 32'h8000) >> 16) & (TILE_SIDE - 1);
		return tile[iy * TILE_SIDE + ix];
	endfunction

	function automatic void apply_reg(input logic [3:0] idx, input logic [31:0] d);
		case (idx)
		REG_CAMERA_HEIGHT: m_height = longint'($signed(d));
		REG_HORIZON_OFFSET: m_horizon = longint'($signed(d[9:0]));
		REG_SCALE_ACROSS: m_sacross = longint'($signed(d));
		REG_SCALE_DEPTH: m_sdepth = longint'($signed(d));
		REG_CAMERA_POS_X: m_posx = longint'($signed(d));
		REG_CAMERA_POS_Y: m_posy = longint'($signed(d));
		REG_VIEW_COSINE: m_cos = longint'($signed(d[17:0]));
		REG_VIEW_SINE: m_sin = longint'($signed(d[17:0]));
		default: ;
		endcase
	endfunction

	function automatic void take_job(input pix_job_t j);
		texel_hit_t h;
		if (j.op == OP_LOAD) begin
			tile[j.trow * TILE_SIDE + j.tcol] = j.texel;
		end else begin
			h.x = j.x;
			h.y = j.y;
			h.colour = floor_texel(j.x, j.y);
			hits_due.push_back(h);
		end
	endfunction

	// sender: bursts and gaps; hold the offer while full
	always @(posedge clk) begin
		bit go;
		go = 0;
		if (arst_n) begin
			if (push && !full) take_job(jobs.pop_front());
			if (!(push && full)) begin
				if (burst_left > 0) begin
					go = 1;
				end else if (gap_left > 0) begin
					gap_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
				if (go && jobs.size() > 0) begin
					burst_left--;
					push <= 1;
					operation <= jobs[0].op;
					tile_col <= jobs[0].tcol;
					tile_row <= jobs[0].trow;
					texel_value <= jobs[0].texel;
					pixel_col <= jobs[0].x;
					pixel_row <= jobs[0].y;
				end else begin
					push <= 0;
				end
			end
		end
	end

	// receiver stall pattern, with an occasional long hold-off
	always @(posedge clk) begin
		if (stall_count == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_count = $urandom_range(20, 120);
		end else begin
			stall_count--;
		end
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 0;
		end else if (stall_mode == 0) begin
			pop <= 1;
		end else if (stall_mode == 1) begin
			pop <= 1'($urandom_range(0, 1));
		end else begin
			pop <= ($urandom_range(0, 4) == 0);
		end
	end

	always @(posedge clk) begin
		texel_hit_t h;
		if (arst_n && pop && !empty) begin
			if (hits_due.size() == 0) begin
				$display("%0t: unexpected result col %0d row %0d colour %0d",
					$time, out_col, out_row, colour);
				errors++;
			end else begin
				h = hits_due.pop_front();
				if (out_col !== h.x) begin
					$display("%0t: out_col expected %0d actual %0d", $time, h.x, out_col);
					errors++;
				end
				if (out_row !== h.y) begin
					$display("%0t: out_row expected %0d actual %0d", $time, h.y, out_row);
					errors++;
				end
				if (colour !== h.colour) begin
					$display("%0t: colour expected %0d actual %0d", $time, h.colour, colour);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("mode7_floor_texture_mapper_unit test failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [3:0] idx, input logic [31:0] d);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		apply_reg(idx, d);
		cfg_valid <= 0;
	endtask

	task automatic write_all(input logic [31:0] v[8]);
		for (int i = 0; i < 8; i++) write_reg(4'(i), v[i]);
		write_reg(REG_UNUSED, $urandom);
	endtask

	task automatic add_render(input int x, input int y);
		pix_job_t j;
		j.op = OP_RENDER;
		j.tcol = 6'($urandom);
		j.trow = 6'($urandom);
		j.texel = 8'($urandom);
		j.x = 9'(x);
		j.y = 8'(y);
		jobs.push_back(j);
	endtask

	task automatic add_random(input int n);
		pix_job_t j;
		for (int i = 0; i < n; i++) begin
			j.op = ($urandom_range(0, 99) < 85) ? OP_RENDER : OP_LOAD;
			j.tcol = 6'($urandom);
			j.trow = 6'($urandom);
			j.texel = 8'($urandom);
			j.x = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
				: 9'($urandom_range(0, 319));
			j.y = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, 199));
			jobs.push_back(j);
		end
	endtask

	task automatic drain();
		wait (jobs.size() == 0 && hits_due.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_angle();
		return 32'($signed($urandom_range(0, 131072)) - 65536);
	endfunction

	initial begin
		pix_job_t j;
		logic [31:0] v[8];
		m_height = 3276800;
		m_horizon = 20;
		m_sacross = 13107200;
		m_sdepth = 13107200;
		m_posx = 0;
		m_posy = 0;
		m_cos = 65536;
		m_sin = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;

		// fill the whole tile so that no render reads an unwritten texel
		for (int r = 0; r < TILE_SIDE; r++)
			for (int c = 0; c < TILE_SIDE; c++) begin
				j.op = OP_LOAD;
				j.tcol = 6'(c);
				j.trow = 6'(r);
				j.texel = 8'($urandom);
				j.x = 9'($urandom);
				j.y = 8'($urandom);
				jobs.push_back(j);
			end
		add_render(0, 0);
		add_render(319, 199);
		add_render(511, 255);
		add_render(160, 100);
		add_render(0, 255);
		add_render(511, 0);
		add_random(150);
		wait (jobs.size() == 0);
		wait (hits_due.size() == 0);
		add_random(100);
		drain();

		// zero row divisor, zero scale, turned camera
		v = '{32'd3276800, 32'hFFFF_FFFB, 32'd0, 32'd13107200, $urandom, $urandom,
			32'hFFFF_0000, 32'd65536};
		write_all(v);
		add_render(0, 5);
		add_render(319, 5);
		add_render(100, 6);
		add_random(200);
		hold_req++;
		add_random(200);
		drain();

		v = '{32'h7FFF_FFFF, 32'd511, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'd65536, 32'hFFFF_0000};
		write_all(v);
		add_render(0, 0);
		add_render(511, 255);
		add_random(120);
		drain();

		// most negative height, horizon offset, scale across and camera position
		v = '{32'h8000_0000, 32'h0000_0200, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'hFFFF_0000, 32'hFFFF_0000};
		write_all(v);
		add_render(0, 0);
		add_render(511, 255);
		add_random(120);
		drain();

		// negative numerator with a zero divisor
		v = '{32'hFFCE_0000, 32'hFFFF_FF38, 32'd13107200, 32'd13107200, $urandom, $urandom,
			32'd0, 32'd65536};
		write_all(v);
		add_render(7, 200);
		add_render(319, 200);
		add_random(120);
		drain();

		for (int p = 0; p < 4; p++) begin
			v[0] = (p[0]) ? $urandom : 32'($urandom_range(0, 8000000));
			v[1] = $urandom;
			v[2] = (p[1]) ? $urandom : 32'($urandom_range(1, 30000000));
			v[3] = (p[1]) ? $urandom : 32'($urandom_range(1, 30000000));
			v[4] = $urandom;
			v[5] = $urandom;
			v[6] = rand_angle();
			v[7] = rand_angle();
			write_all(v);
			add_random(130);
			drain();
		end

		if (errors == 0) begin
			$display("mode7_floor_texture_mapper_unit test passed");
		end else begin
			$display("mode7_floor_texture_mapper_unit test failed");
		end
		$finish;
	end

endmodule
